/* rtl/tcgr_pkg.sv */
// Shared types, codes and defaults for the text console glyph renderer.
package tcgr_pkg;

  localparam int unsigned GlyphCountDef     = 128;
  localparam int unsigned GlyphHeightDef    = 16;
  localparam int unsigned MaxScreenWidthDef = 2048;

  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgW       = 12;
  localparam int unsigned PosW       = 11;
  localparam int unsigned PixIdxW    = 22;
  localparam int unsigned CellW      = 8;
  localparam int unsigned TabCells   = 4;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CfgIdxW-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  localparam logic [CfgW-1:0] WidthRst  = 12'd1680;
  localparam logic [CfgW-1:0] HeightRst = 12'd1050;

  localparam logic KIND_RENDER = 1'b0;
  localparam logic KIND_FONT   = 1'b1;

  localparam logic [7:0] CHAR_NUL      = 8'h00;
  localparam logic [7:0] CHAR_BS       = 8'h08;
  localparam logic [7:0] CHAR_TAB      = 8'h09;
  localparam logic [7:0] CHAR_LF       = 8'h0A;
  localparam logic [7:0] CHAR_CR       = 8'h0D;
  localparam logic [7:0] CHAR_CTRL_MAX = 8'h1F;
  localparam logic [7:0] CHAR_DEL      = 8'h7F;

  typedef enum logic [2:0] {
    OP_FONT_WR,
    OP_GLYPH,
    OP_BS,
    OP_TAB,
    OP_LF,
    OP_CR
  } op_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  char_code;
    logic [10:0] font_address;
    logic [7:0]  font_byte;
  } in_item_t;

  typedef struct packed {
    logic [PixIdxW-1:0] pixel_index;
    logic [7:0]         row_bits;
    logic               last;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic [7:0]  code;
    logic [10:0] addr;
    logic [7:0]  data;
  } cmd_t;

endpackage

/* rtl/tcgr_front.sv */
// Front end: accept items, decode them into commands, drop the ones with no effect.
module tcgr_front #(
  parameter int unsigned GLYPH_COUNT  = tcgr_pkg::GlyphCountDef,
  parameter int unsigned GLYPH_HEIGHT = tcgr_pkg::GlyphHeightDef
) (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tcgr_pkg::in_item_t in_data_i,
  output logic               push_o,
  input  logic               push_ready_i,
  output tcgr_pkg::cmd_t     cmd_o
);

  localparam int unsigned StoreDepth = GLYPH_COUNT * GLYPH_HEIGHT;

  logic keep;

  always_comb begin
    keep       = 1'b0;
    cmd_o.op   = tcgr_pkg::OP_GLYPH;
    cmd_o.code = in_data_i.char_code;
    cmd_o.addr = in_data_i.font_address;
    cmd_o.data = in_data_i.font_byte;
    if (in_data_i.kind == tcgr_pkg::KIND_FONT) begin
      cmd_o.op = tcgr_pkg::OP_FONT_WR;
      keep     = 32'(in_data_i.font_address) < StoreDepth;
    end else if (in_data_i.char_code != tcgr_pkg::CHAR_NUL &&
                 in_data_i.char_code <= tcgr_pkg::CHAR_CTRL_MAX) begin
      case (in_data_i.char_code)
        tcgr_pkg::CHAR_BS: begin
          cmd_o.op = tcgr_pkg::OP_BS;
          keep     = 1'b1;
        end
        tcgr_pkg::CHAR_TAB: begin
          cmd_o.op = tcgr_pkg::OP_TAB;
          keep     = 1'b1;
        end
        tcgr_pkg::CHAR_LF: begin
          cmd_o.op = tcgr_pkg::OP_LF;
          keep     = 1'b1;
        end
        tcgr_pkg::CHAR_CR: begin
          cmd_o.op = tcgr_pkg::OP_CR;
          keep     = 1'b1;
        end
        default: begin
          keep = 1'b0;
        end
      endcase
    end else begin
      keep = (in_data_i.char_code < tcgr_pkg::CHAR_DEL) &&
             (32'(in_data_i.char_code) < GLYPH_COUNT);
    end
  end

  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i && push_ready_i && keep;

endmodule

/* rtl/tcgr_queue.sv */
// Short command queue between the front end and the row sequencer.
module tcgr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           push_ready_o,
  input  tcgr_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output tcgr_pkg::cmd_t pop_data_o
);

  localparam int unsigned Depth = tcgr_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tcgr_pkg::cmd_t slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + CntW'(1))
    else $error("push did not grow queue");

endmodule

/* rtl/tcgr_back.sv */
// Back end: font store, cursor, and glyph row sequencer with output register.
module tcgr_back #(
  parameter int unsigned GLYPH_COUNT      = tcgr_pkg::GlyphCountDef,
  parameter int unsigned GLYPH_HEIGHT     = tcgr_pkg::GlyphHeightDef,
  parameter int unsigned MAX_SCREEN_WIDTH = tcgr_pkg::MaxScreenWidthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  input  tcgr_pkg::cmd_t             cmd_i,
  input  logic [tcgr_pkg::CfgW-1:0]  screen_width_i,
  input  logic [tcgr_pkg::CfgW-1:0]  screen_height_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output tcgr_pkg::out_item_t        out_data_o
);

  localparam int unsigned StoreDepth = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned GlyphW     = $clog2(GLYPH_COUNT);
  localparam int unsigned RowW       = $clog2(GLYPH_HEIGHT);
  localparam int unsigned PosW       = tcgr_pkg::PosW;
  localparam int unsigned IdxW       = tcgr_pkg::PixIdxW;
  localparam int unsigned WW         = tcgr_pkg::CfgW;
  localparam logic [RowW-1:0] RowLast = RowW'(GLYPH_HEIGHT - 1);
  localparam logic [WW:0]     MaxW    = (WW + 1)'(MAX_SCREEN_WIDTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_BASE = 2'd2;
  localparam logic [1:0] ST_ROWS = 2'd3;

  function automatic logic [PosW-1:0] next_row(input logic [PosW-1:0] y,
                                               input logic [WW-1:0] h);
    logic [PosW+1:0] yn;
    logic [PosW+2:0] lim;
    begin
      yn  = {2'b00, y} + (PosW + 2)'(GLYPH_HEIGHT);
      lim = {1'b0, yn} + (PosW + 3)'(GLYPH_HEIGHT);
      if (lim > (PosW + 3)'(h)) begin
        next_row = '0;
      end else begin
        next_row = yn[PosW-1:0];
      end
    end
  endfunction

  logic [7:0]       font_mem [StoreDepth];
  logic [7:0]       rd_data_q;
  logic [1:0]       state_q, state_d;
  logic [PosW-1:0]  x_q, x_d, y_q, y_d;
  logic [AddrW-1:0] glyph_base_q, glyph_base_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [2:0]       cells_q, cells_d;
  logic             stay_q, stay_d;
  logic [IdxW-1:0]  prod_q, run_q, out_idx_q;
  logic             out_valid_q, out_last_q;
  logic [WW-1:0]    w;
  logic [PosW+WW-1:0] prod_full;
  logic             adv, emit, cmd_pop, wr_en;
  logic [AddrW-1:0] rd_addr, wr_addr, code_base;
  logic [WW-1:0]    xn;
  logic             wrap;
  logic [PosW-1:0]  bs_x, bs_y;

  assign w = ({1'b0, screen_width_i} > MaxW) ? MaxW[WW-1:0] : screen_width_i;

  assign adv     = !out_valid_q || out_ready_i;
  assign emit    = (state_q == ST_ROWS) && adv;
  assign rd_addr = glyph_base_q + AddrW'(row_q);
  assign wr_addr = AddrW'(cmd_i.addr);
  assign code_base = AddrW'(32'(cmd_i.code[GlyphW-1:0]) * GLYPH_HEIGHT);
  assign prod_full = y_q * w;

  assign xn   = {1'b0, x_q} + WW'(tcgr_pkg::CellW);
  assign wrap = ({1'b0, xn} + (WW + 1)'(tcgr_pkg::CellW)) >= {1'b0, w};

  always_comb begin
    if (x_q == '0) begin
      bs_x = (w >= WW'(tcgr_pkg::CellW)) ? PosW'(w - WW'(tcgr_pkg::CellW)) : '0;
      bs_y = (y_q >= PosW'(GLYPH_HEIGHT)) ? y_q - PosW'(GLYPH_HEIGHT) : '0;
    end else begin
      bs_x = (x_q >= PosW'(tcgr_pkg::CellW)) ? x_q - PosW'(tcgr_pkg::CellW) : '0;
      bs_y = y_q;
    end
  end

  assign cmd_ready_o = state_q == ST_IDLE;
  assign cmd_pop     = cmd_valid_i && cmd_ready_o;

  always_comb begin
    state_d      = state_q;
    x_d          = x_q;
    y_d          = y_q;
    glyph_base_d = glyph_base_q;
    row_d        = row_q;
    cells_d      = cells_q;
    stay_d       = stay_q;
    wr_en        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_pop) begin
          case (cmd_i.op)
            tcgr_pkg::OP_FONT_WR: begin
              wr_en = 1'b1;
            end
            tcgr_pkg::OP_CR: begin
              x_d = '0;
            end
            tcgr_pkg::OP_LF: begin
              x_d = '0;
              y_d = next_row(y_q, screen_height_i);
            end
            tcgr_pkg::OP_BS: begin
              if (x_q != '0 || y_q != '0) begin
                x_d          = bs_x;
                y_d          = bs_y;
                glyph_base_d = '0;
                cells_d      = 3'd1;
                stay_d       = 1'b1;
                state_d      = ST_MUL;
              end
            end
            tcgr_pkg::OP_TAB: begin
              glyph_base_d = '0;
              cells_d      = 3'(tcgr_pkg::TabCells);
              stay_d       = 1'b0;
              state_d      = ST_MUL;
            end
            tcgr_pkg::OP_GLYPH: begin
              glyph_base_d = code_base;
              cells_d      = 3'd1;
              stay_d       = 1'b0;
              state_d      = ST_MUL;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_MUL: begin
        state_d = ST_BASE;
      end
      ST_BASE: begin
        row_d   = '0;
        state_d = ST_ROWS;
      end
      ST_ROWS: begin
        if (adv) begin
          row_d = row_q + RowW'(1);
          if (row_q == RowLast) begin
            cells_d = cells_q - 3'd1;
            if (!stay_q) begin
              if (wrap) begin
                x_d = '0;
                y_d = next_row(y_q, screen_height_i);
              end else begin
                x_d = xn[PosW-1:0];
              end
            end
            state_d = (cells_q == 3'd1) ? ST_IDLE : ST_MUL;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      x_q          <= '0;
      y_q          <= '0;
      glyph_base_q <= '0;
      row_q        <= '0;
      cells_q      <= '0;
      stay_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      x_q          <= x_d;
      y_q          <= y_d;
      glyph_base_q <= glyph_base_d;
      row_q        <= row_d;
      cells_q      <= cells_d;
      stay_q       <= stay_d;
      if (adv) begin
        out_valid_q <= state_q == ST_ROWS;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_q <= prod_full[IdxW-1:0];
    end
    if (state_q == ST_BASE) begin
      run_q <= prod_q + IdxW'(x_q);
    end else if (emit) begin
      run_q <= run_q + IdxW'(w);
    end
    if (emit) begin
      out_idx_q  <= run_q;
      out_last_q <= (row_q == RowLast) && (cells_q == 3'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      font_mem[wr_addr] <= cmd_i.data;
    end
    if (emit) begin
      rd_data_q <= font_mem[rd_addr];
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_data_o.pixel_index = out_idx_q;
  assign out_data_o.row_bits    = rd_data_q;
  assign out_data_o.last        = out_last_q;

  a_rows_have_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROWS |-> cells_q != '0)
    else $error("row sequencing with no cell pending");

  a_base_starts_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BASE |=> (state_q == ST_ROWS && row_q == '0))
    else $error("rows did not start at row zero");

  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && row_q == RowLast && cells_q == 3'd1) |=> (out_valid_q && out_last_q))
    else $error("final row not marked last");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROWS && out_valid_q && !out_ready_i) |=>
      ($stable(row_q) && $stable(run_q) && $stable(cells_q)))
    else $error("row sequencer moved during output stall");

endmodule

/* rtl/text_console_glyph_renderer.sv */
// Top level of the text console glyph renderer: config registers, front end, queue, back end.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_ready_o  in_data_i  (kind, code, font address, byte)
//   out      output     out_valid_o/out_ready_i  out_data_o (pixel_index, row_bits, last)
//   cfg      input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// A printable character is handled in steps: dequeue, one multiply for the row start, one add,
// then one glyph row per cycle unless the output stalls, from the single font store read port.
// Tab repeats those steps for four cells of glyph 0; font writes, CR and LF finish on dequeue.
// Reset homes the cursor and loads width 1680, height 1050; the font store is not cleared.
// An output stall freezes the row sequencer; a two-entry command queue absorbs input until full.
module text_console_glyph_renderer #(
  parameter int unsigned GLYPH_COUNT      = tcgr_pkg::GlyphCountDef,
  parameter int unsigned GLYPH_HEIGHT     = tcgr_pkg::GlyphHeightDef,
  parameter int unsigned MAX_SCREEN_WIDTH = tcgr_pkg::MaxScreenWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tcgr_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tcgr_pkg::out_item_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tcgr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tcgr_pkg::CfgW-1:0]    cfg_data_i
);

  logic [tcgr_pkg::CfgW-1:0] width_q, height_q;
  logic           push, push_ready, pop_valid, pop;
  tcgr_pkg::cmd_t push_cmd, pop_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= tcgr_pkg::WidthRst;
      height_q <= tcgr_pkg::HeightRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tcgr_pkg::CFG_SCREEN_WIDTH: begin
          width_q <= cfg_data_i;
        end
        tcgr_pkg::CFG_SCREEN_HEIGHT: begin
          height_q <= cfg_data_i;
        end
        default: begin
          width_q <= width_q;
        end
      endcase
    end
  end

  tcgr_front #(
    .GLYPH_COUNT  (GLYPH_COUNT),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .cmd_o        (push_cmd)
  );

  tcgr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_cmd)
  );

  logic back_ready;

  assign pop = pop_valid && back_ready;

  tcgr_back #(
    .GLYPH_COUNT      (GLYPH_COUNT),
    .GLYPH_HEIGHT     (GLYPH_HEIGHT),
    .MAX_SCREEN_WIDTH (MAX_SCREEN_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (pop_valid),
    .cmd_ready_o     (back_ready),
    .cmd_i           (pop_cmd),
    .screen_width_i  (width_q),
    .screen_height_i (height_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_data_o      (out_data_o)
  );

endmodule

/* bench/tb_text_console_glyph_renderer.sv */
`timescale 1ns / 100ps
// Self-checking testbench for text_console_glyph_renderer: directed and random traffic, row-by-row checks.
module tb_text_console_glyph_renderer;
  import tcgr_pkg::*;

  localparam int unsigned GH           = GlyphHeightDef;
  localparam int unsigned StoreDepth   = GlyphCountDef * GlyphHeightDef;
  localparam int unsigned SettleCycles = 100;

  class console_raster;
    logic [CfgW-1:0] width_q;
    logic [CfgW-1:0] height_q;
    logic [PosW-1:0] col_px;
    logic [PosW-1:0] row_px;
    logic [7:0]      font_mem [StoreDepth];
    out_item_t       rows_due [$];
    int unsigned     mismatches;

    function new();
      width_q    = WidthRst;
      height_q   = HeightRst;
      col_px     = '0;
      row_px     = '0;
      mismatches = 0;
      foreach (font_mem[a]) font_mem[a] = '0;
    endfunction

    function int unsigned line_px();
      return (width_q > MaxScreenWidthDef) ? MaxScreenWidthDef : width_q;
    endfunction

    function void next_line();
      int unsigned y;
      y = row_px + GH;
      if (y + GH > height_q) y = 0;
      row_px = PosW'(y);
    endfunction

    function void step_cell();
      int unsigned x;
      x = col_px + CellW;
      if (x + CellW >= line_px()) begin
        x = 0;
        next_line();
      end
      col_px = PosW'(x);
    endfunction

    function void draw(int unsigned glyph, bit mark_last);
      int unsigned w;
      out_item_t   r;
      w = line_px();
      for (int unsigned i = 0; i < GH; i++) begin
        r.pixel_index = PixIdxW'(col_px + (row_px + i) * w);
        r.row_bits    = font_mem[glyph * GH + i];
        r.last        = mark_last && (i == GH - 1);
        rows_due.push_back(r);
      end
      step_cell();
    endfunction

    function void take_cfg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      if (idx == CFG_SCREEN_WIDTH) width_q = val;
      else if (idx == CFG_SCREEN_HEIGHT) height_q = val;
    endfunction

    function void take_char(in_item_t it);
      int unsigned     w;
      logic [PosW-1:0] bx;
      logic [PosW-1:0] by;
      if (it.kind == KIND_FONT) begin
        if (it.font_address < StoreDepth) font_mem[it.font_address] = it.font_byte;
        return;
      end
      case (it.char_code)
        CHAR_BS: begin
          if (col_px == 0 && row_px == 0) return;
          w = line_px();
          if (col_px == 0) begin
            bx = (w >= CellW) ? PosW'(w - CellW) : '0;
            by = (row_px >= GH) ? PosW'(row_px - GH) : '0;
          end else begin
            bx = (col_px >= CellW) ? PosW'(col_px - CellW) : '0;
            by = row_px;
          end
          col_px = bx;
          row_px = by;
          draw(0, 1'b1);
          col_px = bx;
          row_px = by;
        end
        CHAR_TAB: begin
          for (int k = 0; k < TabCells; k++) draw(0, k == TabCells - 1);
        end
        CHAR_LF: begin
          col_px = '0;
          next_line();
        end
        CHAR_CR: begin
          col_px = '0;
        end
        default: begin
          if (it.char_code == CHAR_NUL || (it.char_code > CHAR_CTRL_MAX &&
              it.char_code < CHAR_DEL && it.char_code < GlyphCountDef))
            draw(it.char_code, 1'b1);
        end
      endcase
    endfunction

    function void match_row(out_item_t got);
      out_item_t want;
      if (rows_due.size() == 0) begin
        mismatches++;
        $display("%0t: row with none expected: pixel_index %0d row_bits %02h last %0b",
                 $time, got.pixel_index, got.row_bits, got.last);
        return;
      end
      want = rows_due.pop_front();
      if (got.pixel_index !== want.pixel_index) begin
        mismatches++;
        $display("%0t: pixel_index expected %0d actual %0d",
                 $time, want.pixel_index, got.pixel_index);
      end
      if (got.row_bits !== want.row_bits) begin
        mismatches++;
        $display("%0t: row_bits expected %02h actual %02h", $time, want.row_bits, got.row_bits);
      end
      if (got.last !== want.last) begin
        mismatches++;
        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgW-1:0]     cfg_data;

  bit            font_set [StoreDepth];
  bit            steady;
  console_raster rast = new();

  text_console_glyph_renderer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_text_console_glyph_renderer NOT OK");
    $finish;
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) rast.match_row(out_data);
      out_ready <= steady || ($urandom_range(99) >= 14);
    end
  end

  function automatic bit glyph_ready(int unsigned g);
    for (int unsigned r = 0; r < GH; r++)
      if (!font_set[g * GH + r]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_item(in_item_t it);
    while (!steady && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    rast.take_char(it);
  endtask

  task automatic write_font(logic [10:0] addr, logic [7:0] data);
    in_item_t it;
    it.kind         = KIND_FONT;
    it.char_code    = 8'($urandom);
    it.font_address = addr;
    it.font_byte    = data;
    send_item(it);
    font_set[addr] = 1'b1;
  endtask

  task automatic send_char(logic [7:0] code);
    in_item_t it;
    it.kind         = KIND_RENDER;
    it.char_code    = code;
    it.font_address = 11'($urandom);
    it.font_byte    = 8'($urandom);
    send_item(it);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (rast.rows_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_screen(logic [CfgW-1:0] w, logic [CfgW-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    rast.take_cfg(CFG_SCREEN_WIDTH, w);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_data  <= h;
    do @(posedge clk); while (!cfg_ready);
    rast.take_cfg(CFG_SCREEN_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned done_cnt;
    int unsigned sel;
    int unsigned pick;
    int unsigned g;
    int unsigned ready_q [$];
    logic [7:0]  code;
    done_cnt = 0;
    while (done_cnt < n) begin
      sel = $urandom_range(99);
      if (sel < 4) begin
        pick = $urandom_range(15);
        g = (pick == 0) ? 0 : (pick < 3) ? 8'h7E : (pick < 5) ? 8'h20 :
            $urandom_range(8'h21, 8'h7D);
        for (int unsigned r = 0; r < GH; r++) write_font(11'(g * GH + r), 8'($urandom));
        done_cnt += GH;
      end else if (sel < 10) begin
        write_font(11'($urandom), 8'($urandom));
        done_cnt++;
      end else begin
        if (sel < 55) begin
          ready_q.delete();
          for (int unsigned c = 0; c < CHAR_DEL; c++)
            if ((c == CHAR_NUL || c > CHAR_CTRL_MAX) && glyph_ready(c)) ready_q.push_back(c);
          code = 8'(ready_q[$urandom_range(ready_q.size() - 1)]);
        end else if (sel < 63) code = CHAR_BS;
        else if (sel < 67) code = CHAR_TAB;
        else if (sel < 75) code = CHAR_LF;
        else if (sel < 79) code = CHAR_CR;
        else if (sel < 89) code = 8'($urandom_range(1, CHAR_CTRL_MAX));
        else code = 8'($urandom_range(CHAR_DEL, 8'hFF));
        send_char(code);
        if (!(code >= CHAR_DEL || (code != CHAR_NUL && code <= CHAR_CTRL_MAX &&
              code != CHAR_BS && code != CHAR_TAB && code != CHAR_LF && code != CHAR_CR)))
          done_cnt++;
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data  <= '0;
    steady    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_char(CHAR_BS);
    for (int r = 0; r < GH; r++)
      write_font(11'(r), (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : (r == 2) ? 8'h01 :
                         (r == 3) ? 8'h80 : 8'($urandom));
    write_font(11'h7FF, 8'hA5);
    send_char(CHAR_NUL);
    send_char(CHAR_CR);
    send_char(CHAR_NUL);
    send_char(CHAR_LF);
    send_char(CHAR_BS);
    send_char(CHAR_BS);
    send_char(CHAR_TAB);
    send_char(8'h01);
    send_char(CHAR_CTRL_MAX);
    send_char(8'h0B);
    send_char(CHAR_DEL);
    send_char(8'h80);
    send_char(8'hFF);
    send_char(CHAR_NUL);
    settle();

    set_screen(12'd16, 12'd16);
    random_phase(40);
    settle();
    set_screen(12'd2048, 12'd2048);
    random_phase(40);
    settle();
    steady = 1'b1;
    set_screen(12'($urandom_range(16, 2048)), 12'($urandom_range(16, 2048)));
    random_phase(40);
    settle();
    steady = 1'b0;
    set_screen(WidthRst, HeightRst);
    random_phase(40);
    settle();
    set_screen(12'($urandom_range(16, 2048)), 12'($urandom_range(16, 2048)));
    random_phase(40);
    settle();
    set_screen(12'($urandom_range(16, 40)), 12'd2048);
    random_phase(40);
    settle();

    if (rast.mismatches == 0 && rast.rows_due.size() == 0) begin
      $display("tb_text_console_glyph_renderer OK");
    end else begin
      $display("tb_text_console_glyph_renderer NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tcgr_pkg.sv
rtl/tcgr_front.sv
rtl/tcgr_queue.sv
rtl/tcgr_back.sv
rtl/text_console_glyph_renderer.sv
bench/tb_text_console_glyph_renderer.sv
